>>> rtl/sflc_pkg.sv
// Shared types and constants for the SPI frame LED command controller.
`default_nettype none
package sflc_pkg;

  // LED command codes carried in byte 1 of a frame.
  localparam logic [7:0] CMD_OFF    = 8'hFF;
  localparam logic [7:0] CMD_READY  = 8'h01;
  localparam logic [7:0] CMD_EMERG  = 8'h02;
  localparam logic [7:0] CMD_CENTER = 8'h04;
  localparam logic [7:0] CMD_SELF   = 8'h08;

  // Reset values of the configuration registers and the state.
  localparam logic [3:0] BLINK_TICKS_RST  = 4'd10;
  localparam logic [7:0] FRAME_HEADER_RST = 8'hAA;
  localparam logic [7:0] FRAME_TAIL_RST   = 8'hED;
  localparam logic [7:0] REPLY_CNT_RST    = 8'h01;

  typedef enum logic [1:0] {
    CFG_BLINK_TICKS  = 2'd0,
    CFG_FRAME_HEADER = 2'd1,
    CFG_FRAME_TAIL   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STS_ACCEPTED = 3'd0,
    STS_BAD_FRAME = 3'd1,
    STS_BAD_CHECK = 3'd2,
    STS_DUPLICATE = 3'd3,
    STS_TICK      = 3'd4
  } frame_status_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  rx_header;
    logic [7:0]  rx_data;
    logic [7:0]  rx_status;
    logic [7:0]  rx_seq;
    logic [15:0] rx_reserved;
    logic [7:0]  rx_check;
    logic [7:0]  rx_tail;
  } rx_word_t;

  typedef struct packed {
    logic led_one;
    logic led_two;
  } led_levels_t;

endpackage
`default_nettype wire

>>> rtl/sflc_frame_check.sv
// Frame validation: header and tail, XOR checksum, then duplicate sequence test.
`default_nettype none
module sflc_frame_check
  import sflc_pkg::*;
(
  input  rx_word_t      word_i,
  input  logic [7:0]    frame_header_i,
  input  logic [7:0]    frame_tail_i,
  input  logic [7:0]    last_seq_i,
  output frame_status_e status_o
);

  logic [7:0] xor_sum;

  assign xor_sum = word_i.rx_header ^ word_i.rx_data ^ word_i.rx_status ^ word_i.rx_seq
                 ^ word_i.rx_reserved[7:0] ^ word_i.rx_reserved[15:8];

  always_comb begin
    if ((word_i.rx_header != frame_header_i) || (word_i.rx_tail != frame_tail_i)) begin
      status_o = STS_BAD_FRAME;
    end else if (xor_sum != word_i.rx_check) begin
      status_o = STS_BAD_CHECK;
    end else if (word_i.rx_seq == last_seq_i) begin
      status_o = STS_DUPLICATE;
    end else begin
      status_o = STS_ACCEPTED;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sflc_led_drive.sv
// LED level registers and the shared blink counter, advanced once per tick while a blinking command is set.
`default_nettype none
module sflc_led_drive
  import sflc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  logic [7:0]  command_i,
  input  logic [3:0]  blink_ticks_i,
  output led_levels_t levels_o
);

  logic [3:0] blink_count_q, blink_count_d;
  logic       led_one_q, led_one_d;
  logic       led_two_q, led_two_d;
  logic [3:0] count_inc;
  logic       toggle;
  logic [3:0] count_adv;

  // The counter wraps at four bits; a wrap to zero always counts as due.
  assign count_inc = blink_count_q + 4'd1;
  assign toggle    = (count_inc >= blink_ticks_i) || (count_inc == 4'd0);
  assign count_adv = toggle ? 4'd0 : count_inc;

  always_comb begin
    blink_count_d = blink_count_q;
    led_one_d     = led_one_q;
    led_two_d     = led_two_q;
    if (tick_i) begin
      case (command_i)
        CMD_READY: begin
          led_one_d = 1'b1;
          led_two_d = 1'b0;
        end
        CMD_EMERG: begin
          led_one_d     = 1'b0;
          led_two_d     = led_two_q ^ toggle;
          blink_count_d = count_adv;
        end
        CMD_CENTER: begin
          led_one_d     = led_one_q ^ toggle;
          led_two_d     = led_two_q ^ toggle;
          blink_count_d = count_adv;
        end
        CMD_SELF: begin
          led_one_d     = led_one_q ^ toggle;
          led_two_d     = 1'b1;
          blink_count_d = count_adv;
        end
        default: begin
          led_one_d = 1'b0;
          led_two_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_count_q <= 4'd0;
      led_one_q     <= 1'b0;
      led_two_q     <= 1'b0;
    end else begin
      blink_count_q <= blink_count_d;
      led_one_q     <= led_one_d;
      led_two_q     <= led_two_d;
    end
  end

  // Levels after this cycle's step, so a tick word reports its new levels.
  assign levels_o.led_one = led_one_d;
  assign levels_o.led_two = led_two_d;

endmodule
`default_nettype wire

>>> rtl/spi_frame_led_command_controller.sv
// Top level: input register, frame and tick processing, result register.
// One word can be accepted in every cycle. An accepted word is captured in an input
// register, processed by the frame check and LED logic once the result register is
// free, and presented from that result register. The input side stalls only while
// both registers hold words and the result is not taken. Configuration writes are
// always taken (cfg_ready_o is tied high); index 3 is ignored.
`default_nettype none
module spi_frame_led_command_controller
  import sflc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_header_i,
  input  logic [7:0]  rx_data_i,
  input  logic [7:0]  rx_status_i,
  input  logic [7:0]  rx_seq_i,
  input  logic [15:0] rx_reserved_i,
  input  logic [7:0]  rx_check_i,
  input  logic [7:0]  rx_tail_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  frame_status_o,
  output logic        led_one_o,
  output logic        led_two_o,
  output logic [7:0]  reply_seq_o,
  output logic [7:0]  reply_check_o
);

  logic [3:0]    blink_ticks_q;
  logic [7:0]    frame_header_q;
  logic [7:0]    frame_tail_q;
  logic [7:0]    led_cmd_q, led_cmd_d;
  logic [7:0]    last_seq_q, last_seq_d;
  logic [7:0]    reply_cnt_q, reply_cnt_d;
  logic          in_valid_q, in_valid_d;
  rx_word_t      in_word_q;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    status_q;
  led_levels_t   levels_q;
  logic [7:0]    reply_seq_q;
  logic [7:0]    reply_check_q;
  logic          in_accept;
  logic          out_free;
  logic          proc_fire;
  logic          tick_fire;
  logic          frame_fire;
  frame_status_e chk_status;
  led_levels_t   levels_next;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_ticks_q  <= BLINK_TICKS_RST;
      frame_header_q <= FRAME_HEADER_RST;
      frame_tail_q   <= FRAME_TAIL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BLINK_TICKS:  blink_ticks_q  <= cfg_data_i[3:0];
        CFG_FRAME_HEADER: frame_header_q <= cfg_data_i;
        CFG_FRAME_TAIL:   frame_tail_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake between the input register and the result register.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;
  assign proc_fire  = in_valid_q && out_free;
  assign tick_fire  = proc_fire && in_word_q.mode;
  assign frame_fire = proc_fire && !in_word_q.mode;

  assign in_valid_d  = in_accept || (in_valid_q && !proc_fire);
  assign out_valid_d = proc_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q.mode        <= mode_i;
      in_word_q.rx_header   <= rx_header_i;
      in_word_q.rx_data     <= rx_data_i;
      in_word_q.rx_status   <= rx_status_i;
      in_word_q.rx_seq      <= rx_seq_i;
      in_word_q.rx_reserved <= rx_reserved_i;
      in_word_q.rx_check    <= rx_check_i;
      in_word_q.rx_tail     <= rx_tail_i;
    end
  end

  sflc_frame_check u_frame_check (
    .word_i         (in_word_q),
    .frame_header_i (frame_header_q),
    .frame_tail_i   (frame_tail_q),
    .last_seq_i     (last_seq_q),
    .status_o       (chk_status)
  );

  sflc_led_drive u_led_drive (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick_fire),
    .command_i     (led_cmd_q),
    .blink_ticks_i (blink_ticks_q),
    .levels_o      (levels_next)
  );

  always_comb begin
    led_cmd_d   = led_cmd_q;
    last_seq_d  = last_seq_q;
    reply_cnt_d = reply_cnt_q;
    if (frame_fire) begin
      // Every frame loads a reply, even a rejected one.
      reply_cnt_d = reply_cnt_q + 8'd1;
      if (chk_status == STS_ACCEPTED) begin
        led_cmd_d  = in_word_q.rx_data;
        last_seq_d = in_word_q.rx_seq;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_cmd_q   <= CMD_OFF;
      last_seq_q  <= 8'd0;
      reply_cnt_q <= REPLY_CNT_RST;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      led_cmd_q   <= led_cmd_d;
      last_seq_q  <= last_seq_d;
      reply_cnt_q <= reply_cnt_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      levels_q <= levels_next;
      if (in_word_q.mode) begin
        status_q      <= STS_TICK;
        reply_seq_q   <= 8'd0;
        reply_check_q <= 8'd0;
      end else begin
        status_q      <= chk_status;
        reply_seq_q   <= reply_cnt_q;
        reply_check_q <= frame_header_q ^ reply_cnt_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign led_one_o      = levels_q.led_one;
  assign led_two_o      = levels_q.led_two;
  assign reply_seq_o    = reply_seq_q;
  assign reply_check_o  = reply_check_q;

endmodule
`default_nettype wire

>>> rtl/sflc_checker.sv
// Port-level checks for the SPI frame LED command controller, bound to the top level.
`default_nettype none
module sflc_checker
  import sflc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] frame_status_o,
  input logic       led_one_o,
  input logic       led_two_o,
  input logic [7:0] reply_seq_o,
  input logic [7:0] reply_check_o
);

  // A stalled result word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_status_o)
      && $stable(led_one_o) && $stable(led_two_o) && $stable(reply_seq_o)
      && $stable(reply_check_o))
    else $error("stalled result word changed");

  // Only the five defined status codes are ever reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_status_o == STS_ACCEPTED) || (frame_status_o == STS_BAD_FRAME)
      || (frame_status_o == STS_BAD_CHECK) || (frame_status_o == STS_DUPLICATE)
      || (frame_status_o == STS_TICK))
    else $error("undefined frame status");

  // A tick carries no reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == STS_TICK) |-> (reply_seq_o == 8'd0)
      && (reply_check_o == 8'd0))
    else $error("tick result carries a reply");

  // The input side only stalls while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind spi_frame_led_command_controller sflc_checker u_sflc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .frame_status_o (frame_status_o),
  .led_one_o      (led_one_o),
  .led_two_o      (led_two_o),
  .reply_seq_o    (reply_seq_o),
  .reply_check_o  (reply_check_o)
);
`default_nettype wire
